### design/gtdd_pkg.sv
// Shared types and constants for the generation-tagged duplicate detector.
// No dependencies; used by gtdd_ctrl and generation_tagged_duplicate_detector_core.
package gtdd_pkg;

  // Fixed field widths of the stream ports
  localparam int ITEM_ID_W   = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 8;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,   // sweep the tag store after reset
    ST_RUN,     // normal operation
    ST_DRAIN,   // generation wrapped: let the pipeline empty
    ST_WIPE,    // sweep the tag store after a wrap
    ST_REPLAY   // issue the parked item in generation 1
  } gtdd_state_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic run;     // items may be taken
    logic wiping;  // store sweep writes zeros this cycle
    logic replay;  // load the parked item into the compare stage
    logic park;    // the item taken this cycle wraps the generation
  } gtdd_ctl_t;

endpackage

### design/gtdd_tag_ram.sv
// Tag store: one write port, one read port, registered read data.
// No dependencies.
module gtdd_tag_ram #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] wa,
  input  logic [DATA_BITS-1:0] wd,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] ra,
  output logic [DATA_BITS-1:0] rd
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
  logic [DATA_BITS-1:0] rd_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Read old data; hold the last read while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

### design/gtdd_ctrl.sv
// Sequencer for the duplicate detector: generation register, store sweeps, wrap handling.
// Depends on gtdd_pkg.
module gtdd_ctrl #(
  parameter int ID_BITS  = 16,
  parameter int TAG_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                start_new_set,
  input  logic                s1_busy,
  output gtdd_pkg::gtdd_ctl_t ctl,
  output logic [ID_BITS-1:0]  wipe_addr,
  output logic [TAG_BITS-1:0] item_gen
);

  gtdd_pkg::gtdd_state_t state_r, state_nxt;
  logic [ID_BITS-1:0]    cnt_r, cnt_nxt;
  logic [TAG_BITS-1:0]   gen_r, gen_nxt;
  logic                  cnt_last;
  logic                  wrap;

  assign cnt_last = (cnt_r == '1);
  assign wrap     = in_fire && start_new_set && (gen_r == '1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gtdd_pkg::ST_CLEAR: begin
        if (cnt_last) state_nxt = gtdd_pkg::ST_RUN;
      end
      gtdd_pkg::ST_RUN: begin
        if (wrap) state_nxt = gtdd_pkg::ST_DRAIN;
      end
      gtdd_pkg::ST_DRAIN: begin
        if (!s1_busy) state_nxt = gtdd_pkg::ST_WIPE;
      end
      gtdd_pkg::ST_WIPE: begin
        if (cnt_last) state_nxt = gtdd_pkg::ST_REPLAY;
      end
      gtdd_pkg::ST_REPLAY: begin
        state_nxt = gtdd_pkg::ST_RUN;
      end
      default: begin
        state_nxt = gtdd_pkg::ST_CLEAR;
      end
    endcase
  end

  // Outputs per state
  always_comb begin
    ctl      = '0;
    item_gen = start_new_set ? (gen_r + TAG_BITS'(1)) : gen_r;
    case (state_r)
      gtdd_pkg::ST_CLEAR: begin
        ctl.wiping = 1'b1;
      end
      gtdd_pkg::ST_RUN: begin
        ctl.run  = 1'b1;
        ctl.park = wrap;
      end
      gtdd_pkg::ST_DRAIN: begin
        ctl.run = 1'b0;
      end
      gtdd_pkg::ST_WIPE: begin
        ctl.wiping = 1'b1;
      end
      gtdd_pkg::ST_REPLAY: begin
        ctl.replay = 1'b1;
        item_gen   = TAG_BITS'(1);
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  assign wipe_addr = cnt_r;

  // Advance sweep counter and generation
  always_comb begin
    cnt_nxt = ctl.wiping ? (cnt_r + ID_BITS'(1)) : '0;
    gen_nxt = gen_r;
    if (ctl.replay) begin
      gen_nxt = TAG_BITS'(1);
    end else if (in_fire && start_new_set && !wrap) begin
      gen_nxt = gen_r + TAG_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtdd_pkg::ST_CLEAR;
      cnt_r   <= '0;
      gen_r   <= '1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      gen_r   <= gen_nxt;
    end
  end

endmodule

### design/generation_tagged_duplicate_detector_core.sv
// Top level of the generation-tagged duplicate detector: read stage, compare/write stage, output.
// Depends on gtdd_pkg, gtdd_tag_ram and gtdd_ctrl.
//
//  channel | dir | tdata                        | tuser
//  in_     | in  | [15:0] item_id               | [0] start_new_set
//  out_    | out | [0] duplicate, [7:1] zero    | -
//
// Sustained rate is one item per cycle while out_tready is high; a taken item passes through
// the compare stage into the output register, which drives out_tvalid. The tag store has one
// read and one write port: it is read when an item is taken and written as the item leaves
// the compare stage; a write to the same tag is forwarded into the compare.
// After reset the store is swept with in_tready low.
// A generation wrap drains the pipeline, sweeps the store and then replays the wrapping item,
// with in_tready low throughout.
// out_tready low holds the compare stage and, once it is full, the input.
module generation_tagged_duplicate_detector_core #(
  parameter int ID_BITS  = 16,
  parameter int TAG_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gtdd_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] item_id
  input  logic [gtdd_pkg::IN_TUSER_W-1:0]  in_tuser,   // [0] start_new_set
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gtdd_pkg::OUT_TDATA_W-1:0] out_tdata   // [0] duplicate, rest zero
);

  localparam int ID_EXT_W = (ID_BITS > gtdd_pkg::ITEM_ID_W) ? ID_BITS : gtdd_pkg::ITEM_ID_W;

  gtdd_pkg::gtdd_ctl_t ctl;
  logic [ID_BITS-1:0]  wipe_addr;
  logic [TAG_BITS-1:0] item_gen;

  logic [ID_EXT_W-1:0] id_ext;
  logic [ID_BITS-1:0]  in_idx;
  logic                in_fire;
  logic                s1_load;
  logic                s1_fire;
  logic                out_free;

  logic                s1_valid_r;
  logic [ID_BITS-1:0]  s1_idx_r;
  logic [TAG_BITS-1:0] s1_gen_r;
  logic [ID_BITS-1:0]  park_idx_r;

  logic                fwd_valid_r;
  logic [ID_BITS-1:0]  fwd_idx_r;
  logic [TAG_BITS-1:0] fwd_tag_r;

  logic                out_valid_r;
  logic                dup_r;

  logic                ram_we;
  logic [ID_BITS-1:0]  ram_wa;
  logic [TAG_BITS-1:0] ram_wd;
  logic [ID_BITS-1:0]  ram_ra;
  logic [TAG_BITS-1:0] ram_rd;
  logic [TAG_BITS-1:0] cur_tag;
  logic                dup;

  // Take the identifier's low ID_BITS bits
  assign id_ext = ID_EXT_W'(in_tdata[gtdd_pkg::ITEM_ID_W-1:0]);
  assign in_idx = id_ext[ID_BITS-1:0];

  // Handshake and stage moves
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = ctl.run && (!s1_valid_r || s1_fire);
  assign in_fire   = in_tvalid && in_tready;
  assign s1_load   = (in_fire && !ctl.park) || ctl.replay;

  gtdd_ctrl #(
    .ID_BITS  (ID_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .start_new_set (in_tuser[0]),
    .s1_busy       (s1_valid_r),
    .ctl           (ctl),
    .wipe_addr     (wipe_addr),
    .item_gen      (item_gen)
  );

  // Select store port addresses: sweep or compare-stage write, item or parked read
  assign ram_we = ctl.wiping || s1_fire;
  assign ram_wa = ctl.wiping ? wipe_addr : s1_idx_r;
  assign ram_wd = ctl.wiping ? '0 : s1_gen_r;
  assign ram_ra = ctl.replay ? park_idx_r : in_idx;

  gtdd_tag_ram #(
    .ADDR_BITS (ID_BITS),
    .DATA_BITS (TAG_BITS)
  ) u_tag_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (s1_load),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  // Forward the last written tag over the stale read
  assign cur_tag = (fwd_valid_r && (fwd_idx_r == s1_idx_r)) ? fwd_tag_r : ram_rd;
  assign dup     = (cur_tag == s1_gen_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (ctl.wiping) begin
        fwd_valid_r <= 1'b0;
      end else if (s1_fire) begin
        fwd_valid_r <= 1'b1;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      park_idx_r <= in_idx;
    end
    if (s1_load) begin
      s1_idx_r <= ram_ra;
      s1_gen_r <= item_gen;
    end
    if (s1_fire) begin
      fwd_idx_r <= s1_idx_r;
      fwd_tag_r <= s1_gen_r;
      dup_r     <= dup;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = gtdd_pkg::OUT_TDATA_W'(dup_r);

`ifndef SYNTHESIS
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.wiping && s1_fire))
    else $error("compare-stage write during store sweep");

  a_take_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!s1_valid_r || s1_fire))
    else $error("item taken while compare stage is held");

  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_gen_r != '0))
    else $error("compare stage holds generation zero");

  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |=> s1_valid_r)
    else $error("compare stage empty after load");
`endif

endmodule

### test/tb_generation_tagged_duplicate_detector_core.sv
// Self-checking bench for generation_tagged_duplicate_detector_core: directed table, then random sets.
// Depends on gtdd_pkg and the detector RTL; predicts each untyped item's duplicate flag from a mirror tag store.
`timescale 1ns / 1ps

module tb_generation_tagged_duplicate_detector_core;

  localparam int ID_BITS   = 16;
  localparam int TAG_BITS  = 8;
  localparam int DEPTH     = 1 << ID_BITS;
  localparam int N_RANDOM  = 650;
  localparam int N_DIRECT  = 20;
  localparam int MAX_GAP   = 10;
  localparam int HOLD_LONG = 400;

  typedef logic [gtdd_pkg::ITEM_ID_W-1:0] item_id_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [gtdd_pkg::IN_TDATA_W-1:0]  in_tdata;   // [15:0] item_id
  logic [gtdd_pkg::IN_TUSER_W-1:0]  in_tuser;   // [0] start_new_set
  logic                             out_tvalid;
  logic                             out_tready;
  logic [gtdd_pkg::OUT_TDATA_W-1:0] out_tdata;  // [0] duplicate, [7:1] zero

  generation_tagged_duplicate_detector_core #(
    .ID_BITS (ID_BITS),
    .TAG_BITS(TAG_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // One directed item; typed rows carry their duplicate flag, others use the mirror
  typedef struct packed {
    item_id_t id;
    logic     start;
    logic     typed;
    logic     dup;
  } stim_row_t;

  stim_row_t dir_rows [N_DIRECT] = '{
    '{16'h0000, 1'b0, 1'b1, 1'b0},  // reset generation, fresh tag
    '{16'h0000, 1'b0, 1'b1, 1'b1},  // repeat in reset generation
    '{16'hFFFF, 1'b0, 1'b1, 1'b0},  // top identifier
    '{16'hFFFF, 1'b0, 1'b1, 1'b1},
    '{16'h0000, 1'b1, 1'b1, 1'b0},  // first new set wraps: store cleared, generation 1
    '{16'h0000, 1'b0, 1'b1, 1'b1},
    '{16'hFFFF, 1'b0, 1'b1, 1'b0},  // mark from before the wrap is gone
    '{16'hFFFF, 1'b0, 1'b0, 1'b0},
    '{16'h0000, 1'b1, 1'b0, 1'b0},
    '{16'h0000, 1'b1, 1'b0, 1'b0},  // back-to-back new sets
    '{16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h5555, 1'b0, 1'b0, 1'b0},
    '{16'hAAAA, 1'b0, 1'b0, 1'b0},
    '{16'h5555, 1'b0, 1'b0, 1'b0},
    '{16'hAAAA, 1'b1, 1'b0, 1'b0},
    '{16'hAAAA, 1'b0, 1'b0, 1'b0},
    '{16'h5555, 1'b0, 1'b0, 1'b0},
    '{16'h0007, 1'b0, 1'b0, 1'b0},  // same tag three times: write forwarding
    '{16'h0007, 1'b0, 1'b0, 1'b0},
    '{16'h0007, 1'b0, 1'b0, 1'b0}
  };

  // Mirror of the tag store and the current generation
  logic [TAG_BITS-1:0] tag_mirror [DEPTH];
  logic [TAG_BITS-1:0] cur_gen;
  int                  wrap_count;

  logic dup_expected [$];
  int   mismatches;
  int   items_sent;
  int   results_seen;
  bit   tx_burst;
  bit   rx_burst;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic clear_tag_mirror();
    for (int i = 0; i < DEPTH; i++) tag_mirror[i] = '0;
  endtask

  // Advance the generation on a new set, then test and mark the tag
  task automatic mark_and_test(input item_id_t id, input logic start,
                               output logic dup);
    logic [ID_BITS-1:0] idx;
    idx = id[ID_BITS-1:0];
    if (start) begin
      cur_gen = cur_gen + 1'b1;
      if (cur_gen == '0) begin
        clear_tag_mirror();
        cur_gen = TAG_BITS'(1);
        wrap_count++;
      end
    end
    dup = (tag_mirror[idx] == cur_gen);
    tag_mirror[idx] = cur_gen;
  endtask

  // Offer one item after a random gap, hold until taken, then log its expected flag
  task automatic send_item(input item_id_t id, input logic start,
                           input logic typed, input logic typed_dup);
    int   gap;
    logic dup;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    in_tuser  <= start;
    do @(posedge clk); while (in_tready !== 1'b1);
    mark_and_test(id, start, dup);
    dup_expected.push_back(typed ? typed_dup : dup);
    items_sent++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stalls, two long hold-offs, compare against the oldest expectation
  initial begin
    int   stall;
    logic exp_dup;
    out_tready <= 1'b0;
    rx_burst = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (results_seen % 60 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (results_seen == 150 || results_seen == 450) stall = HOLD_LONG;
      else stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      results_seen++;
      if (dup_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d with no item pending, tdata=%h",
                                  results_seen, out_tdata));
      end else begin
        exp_dup = dup_expected.pop_front();
        if (out_tdata !== {{(gtdd_pkg::OUT_TDATA_W-1){1'b0}}, exp_dup})
          report_mismatch($sformatf("result %0d: tdata=%h, duplicate expected %0b",
                                    results_seen, out_tdata, exp_dup));
      end
    end
  end

  // Reset, stimulus, end of run
  initial begin
    item_id_t base;
    int       span;
    int       n;
    int       seg;
    int       wraps_at_entry;
    bit       forced_wrap;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    wrap_count = 0;
    tx_burst   = 1'b0;
    forced_wrap = 1'b0;
    base       = '0;
    clear_tag_mirror();
    cur_gen    = '1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_rows[i])
      send_item(dir_rows[i].id, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].dup);

    // Random part: mostly sets of nearby identifiers opened by start_new_set
    while (items_sent < N_DIRECT + N_RANDOM) begin
      seg      = $urandom_range(0, 99);
      tx_burst = ($urandom_range(0, 4) == 0);
      if (!forced_wrap && items_sent >= 250) begin
        // Push the generation through all ones so it wraps once more
        wraps_at_entry = wrap_count;
        base = item_id_t'($urandom);
        while (wrap_count == wraps_at_entry)
          send_item(item_id_t'(base + $urandom_range(0, 3)), ($urandom_range(0, 7) != 0),
                    1'b0, 1'b0);
        forced_wrap = 1'b1;
      end else if (seg < 70) begin
        base = item_id_t'($urandom);
        span = $urandom_range(1, 15);
        n    = $urandom_range(1, 12);
        send_item(item_id_t'(base + $urandom_range(0, span)), 1'b1, 1'b0, 1'b0);
        repeat (n) send_item(item_id_t'(base + $urandom_range(0, span)), 1'b0, 1'b0, 1'b0);
      end else if (seg < 85) begin
        // Noise: any identifier, any start bit
        n = $urandom_range(1, 5);
        repeat (n) send_item(item_id_t'($urandom), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end else begin
        // Broken set: keep marking around the last base without a new start
        n = $urandom_range(1, 6);
        repeat (n) send_item(item_id_t'(base + $urandom_range(0, 15)), 1'b0, 1'b0, 1'b0);
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then allow for the pipeline latency
    while (dup_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
